// ===== hw/rtl/mx3_pkg.sv =====
// Shared constants, operation codes and the job type of the 3x3 matrix add/subtract/multiply block.
package mx3_pkg;

    localparam int DIM_DEFAULT        = 3;
    localparam int ELEM_WIDTH_DEFAULT = 16;
    localparam int OUT_WIDTH          = 33;
    localparam int IDX_WIDTH          = 2;
    localparam int OP_WIDTH           = 2;
    localparam int M_TDATA_WIDTH      = ((OUT_WIDTH + 2 * IDX_WIDTH + 7) / 8) * 8;
    localparam int JOBQ_DEPTH         = 2;

    localparam logic [OP_WIDTH-1:0] OP_ADD     = 2'd0;
    localparam logic [OP_WIDTH-1:0] OP_SUB     = 2'd1;
    localparam logic [OP_WIDTH-1:0] OP_MUL     = 2'd2;
    // Code three multiplies as well.
    localparam logic [OP_WIDTH-1:0] OP_MUL_ALT = 2'd3;

    typedef struct packed {
        logic [OP_WIDTH-1:0] op;
        logic                bank;
    } job_t;

endpackage

// ===== hw/rtl/mx3_front.sv =====
// Front end: accepts elements, writes them into the matrix banks and posts a job per full run.
module mx3_front
    import mx3_pkg::*;
#(
    parameter int DIM        = DIM_DEFAULT,
    parameter int ELEM_WIDTH = ELEM_WIDTH_DEFAULT
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [((ELEM_WIDTH + 7) / 8) * 8-1:0] s_tdata,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [OP_WIDTH-1:0]                   cfg_data,
    input  logic                                  q_full,
    output logic                                  push_valid,
    output job_t                                  push_job,
    output logic                                  wr_en_a,
    output logic                                  wr_en_b,
    output logic [$clog2(2 * DIM * DIM)-1:0]      wr_addr,
    output logic [ELEM_WIDTH-1:0]                 wr_data
);

    localparam int CELLS = DIM * DIM;
    localparam int CW    = $clog2(CELLS);
    localparam int AW    = $clog2(2 * CELLS);

    logic [CW-1:0]       idx_reg, idx_next;
    logic                half_reg, half_next;
    logic                bank_reg, bank_next;
    logic [OP_WIDTH-1:0] op_reg;
    logic                accept;
    logic                idx_last;

    assign s_tready  = !q_full;
    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;
    assign idx_last  = (idx_reg == CW'(CELLS - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_reg <= OP_ADD;
        end else if (cfg_valid) begin
            op_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg  <= '0;
            half_reg <= 1'b0;
            bank_reg <= 1'b0;
        end else begin
            idx_reg  <= idx_next;
            half_reg <= half_next;
            bank_reg <= bank_next;
        end
    end

    always_comb begin
        idx_next  = idx_reg;
        half_next = half_reg;
        bank_next = bank_reg;
        if (accept) begin
            if (idx_last) begin
                idx_next  = '0;
                half_next = !half_reg;
                // A finished second matrix hands its bank over to the back end.
                if (half_reg) begin
                    bank_next = !bank_reg;
                end
            end else begin
                idx_next = idx_reg + 1'b1;
            end
        end
    end

    assign push_valid = accept && half_reg && idx_last;
    assign push_job   = '{op: op_reg, bank: bank_reg};

    assign wr_en_a = accept && !half_reg;
    assign wr_en_b = accept && half_reg;
    assign wr_addr = (bank_reg ? AW'(CELLS) : AW'(0)) + AW'(idx_reg);
    assign wr_data = s_tdata[ELEM_WIDTH-1:0];

endmodule

// ===== hw/rtl/mx3_jobq.sv =====
// Two-entry job queue between the front end and the compute back end.
module mx3_jobq
    import mx3_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push_valid,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output job_t head_job
);

    localparam int PTRW = $clog2(JOBQ_DEPTH);
    localparam int CNTW = $clog2(JOBQ_DEPTH + 1);

    job_t            entry_reg [JOBQ_DEPTH];
    logic [PTRW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNTW-1:0] count_reg, count_next;

    assign full       = (count_reg == CNTW'(JOBQ_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push_valid) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_comb begin
        count_next = count_reg;
        if (push_valid && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push_valid) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push_valid) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNTW'(JOBQ_DEPTH))
        else $error("job queue holds more jobs than it has entries");

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> head_valid)
        else $error("job popped from an empty queue");

    a_push_not_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push_valid |-> !full)
        else $error("job pushed into a full queue");

endmodule

// ===== hw/rtl/mx3_back.sv =====
// Back end: matrix banks, term issue counters, multiply/add pipeline, accumulator and output register.
module mx3_back
    import mx3_pkg::*;
#(
    parameter int DIM        = DIM_DEFAULT,
    parameter int ELEM_WIDTH = ELEM_WIDTH_DEFAULT
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             wr_en_a,
    input  logic                             wr_en_b,
    input  logic [$clog2(2 * DIM * DIM)-1:0] wr_addr,
    input  logic [ELEM_WIDTH-1:0]            wr_data,
    input  logic                             head_valid,
    input  job_t                             head_job,
    output logic                             pop,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [M_TDATA_WIDTH-1:0]         m_tdata,
    output logic                             m_tlast
);

    localparam int CELLS = DIM * DIM;
    localparam int CW    = $clog2(CELLS);
    localparam int AW    = $clog2(2 * CELLS);
    localparam int KW    = $clog2(DIM);
    localparam int PW    = (2 * ELEM_WIDTH > OUT_WIDTH) ? 2 * ELEM_WIDTH : OUT_WIDTH;

    logic [ELEM_WIDTH-1:0] mem_a [2 * CELLS];
    logic [ELEM_WIDTH-1:0] mem_b [2 * CELLS];

    // Issue counters
    logic [KW-1:0] r_reg, r_next, c_reg, c_next, k_reg, k_next;
    logic [CW-1:0] row_base_reg, row_base_next, k_row_reg, k_row_next;
    logic          adv, issue, is_mul, last_k, last_c, last_r;
    logic [AW-1:0] bank_base, a_addr, b_addr;

    // Read stage
    logic                  s1_valid_reg, s1_first_reg, s1_last_reg, s1_end_reg;
    logic [OP_WIDTH-1:0]   s1_op_reg;
    logic [IDX_WIDTH-1:0]  s1_row_reg, s1_col_reg;
    logic [ELEM_WIDTH-1:0] a_rd_reg, b_rd_reg;

    // Term stage
    logic                  s2_valid_reg, s2_first_reg, s2_last_reg, s2_end_reg;
    logic [IDX_WIDTH-1:0]  s2_row_reg, s2_col_reg;
    logic [OUT_WIDTH-1:0]  s2_term_reg, term_next;

    logic signed [ELEM_WIDTH-1:0]   a_s, b_s;
    logic signed [2*ELEM_WIDTH-1:0] prod;
    logic signed [PW-1:0]           prod_w, sum_w, diff_w;

    // Accumulate and output
    logic [OUT_WIDTH-1:0] acc_reg, acc_sum;
    logic [OUT_WIDTH-1:0] out_value_reg;
    logic [IDX_WIDTH-1:0] out_row_reg, out_col_reg;
    logic                 out_valid_reg, out_last_reg;

    // The whole pipeline holds while a result waits in the output register.
    assign adv = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (wr_en_a) begin
            mem_a[wr_addr] <= wr_data;
        end
        if (wr_en_b) begin
            mem_b[wr_addr] <= wr_data;
        end
    end

    assign is_mul = (head_job.op == OP_MUL) || (head_job.op == OP_MUL_ALT);
    assign last_k = !is_mul || (k_reg == KW'(DIM - 1));
    assign last_c = (c_reg == KW'(DIM - 1));
    assign last_r = (r_reg == KW'(DIM - 1));
    assign issue  = adv && head_valid;
    // The bank is released once its last read is issued.
    assign pop    = issue && last_k && last_c && last_r;

    assign bank_base = head_job.bank ? AW'(CELLS) : AW'(0);
    assign a_addr    = bank_base + AW'(row_base_reg) + AW'(is_mul ? k_reg : c_reg);
    assign b_addr    = is_mul ? bank_base + AW'(k_row_reg) + AW'(c_reg) : a_addr;

    always_comb begin
        r_next        = r_reg;
        c_next        = c_reg;
        k_next        = k_reg;
        row_base_next = row_base_reg;
        k_row_next    = k_row_reg;
        if (issue) begin
            if (last_k) begin
                k_next     = '0;
                k_row_next = '0;
                if (last_c) begin
                    c_next = '0;
                    if (last_r) begin
                        r_next        = '0;
                        row_base_next = '0;
                    end else begin
                        r_next        = r_reg + 1'b1;
                        row_base_next = row_base_reg + CW'(DIM);
                    end
                end else begin
                    c_next = c_reg + 1'b1;
                end
            end else begin
                k_next     = k_reg + 1'b1;
                k_row_next = k_row_reg + CW'(DIM);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r_reg        <= '0;
            c_reg        <= '0;
            k_reg        <= '0;
            row_base_reg <= '0;
            k_row_reg    <= '0;
        end else begin
            r_reg        <= r_next;
            c_reg        <= c_next;
            k_reg        <= k_next;
            row_base_reg <= row_base_next;
            k_row_reg    <= k_row_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= head_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            a_rd_reg     <= mem_a[a_addr];
            b_rd_reg     <= mem_b[b_addr];
            s1_op_reg    <= head_job.op;
            s1_first_reg <= (k_reg == '0);
            s1_last_reg  <= last_k;
            s1_end_reg   <= last_k && last_c && last_r;
            s1_row_reg   <= IDX_WIDTH'(r_reg);
            s1_col_reg   <= IDX_WIDTH'(c_reg);
        end
    end

    assign a_s    = a_rd_reg;
    assign b_s    = b_rd_reg;
    assign prod   = a_s * b_s;
    assign prod_w = PW'(prod);
    assign sum_w  = PW'(a_s) + PW'(b_s);
    assign diff_w = PW'(a_s) - PW'(b_s);

    always_comb begin
        case (s1_op_reg)
            OP_ADD:  term_next = sum_w[OUT_WIDTH-1:0];
            OP_SUB:  term_next = diff_w[OUT_WIDTH-1:0];
            default: term_next = prod_w[OUT_WIDTH-1:0];
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (adv) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && s1_valid_reg) begin
            s2_term_reg  <= term_next;
            s2_first_reg <= s1_first_reg;
            s2_last_reg  <= s1_last_reg;
            s2_end_reg   <= s1_end_reg;
            s2_row_reg   <= s1_row_reg;
            s2_col_reg   <= s1_col_reg;
        end
    end

    // Sums wrap at the output width, which matches the reduction of the exact result.
    assign acc_sum = s2_first_reg ? s2_term_reg : acc_reg + s2_term_reg;

    always_ff @(posedge aclk) begin
        if (adv && s2_valid_reg) begin
            if (s2_last_reg) begin
                out_value_reg <= acc_sum;
                out_row_reg   <= s2_row_reg;
                out_col_reg   <= s2_col_reg;
                out_last_reg  <= s2_end_reg;
            end else begin
                acc_reg <= acc_sum;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= s2_valid_reg && s2_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = M_TDATA_WIDTH'({out_col_reg, out_row_reg, out_value_reg});

    a_last_is_corner: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_last_reg |->
            out_row_reg == IDX_WIDTH'(DIM - 1) && out_col_reg == IDX_WIDTH'(DIM - 1))
        else $error("final result item is not the bottom right element");

    a_counters_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> r_reg == '0 && c_reg == '0 && k_reg == '0)
        else $error("issue counters did not restart after a job");

endmodule

// ===== hw/rtl/matrix3x3_add_sub_mul.sv =====
// Top level of the streaming 3x3 matrix add / subtract / multiply block.
// Elements load at one item per cycle; the input stalls only while two full runs wait in the
// job queue. With the back end idle, a finished run's first result passes the read stage, term
// stage and output register. Add and subtract then give one item per cycle while m_tready
// is high; multiply gives one item per DIM terms, which all share the single multiplier.
// Synchronous reset (aresetn low) clears counters, queue and operation.
module matrix3x3_add_sub_mul
    import mx3_pkg::*;
#(
    parameter int DIM        = DIM_DEFAULT,
    parameter int ELEM_WIDTH = ELEM_WIDTH_DEFAULT
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // s_tdata: element_value
    input  logic [((ELEM_WIDTH + 7) / 8) * 8-1:0] s_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // m_tdata: result_value, result_row, result_col, zero fill
    output logic [M_TDATA_WIDTH-1:0]              m_tdata,
    output logic                                  m_tlast,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [OP_WIDTH-1:0]                   cfg_data
);

    localparam int AW = $clog2(2 * DIM * DIM);

    logic                  q_full, push_valid, pop, head_valid;
    job_t                  push_job, head_job;
    logic                  wr_en_a, wr_en_b;
    logic [AW-1:0]         wr_addr;
    logic [ELEM_WIDTH-1:0] wr_data;

    mx3_front #(
        .DIM        (DIM),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .q_full     (q_full),
        .push_valid (push_valid),
        .push_job   (push_job),
        .wr_en_a    (wr_en_a),
        .wr_en_b    (wr_en_b),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data)
    );

    mx3_jobq u_jobq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_job   (push_job),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    mx3_back #(
        .DIM        (DIM),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .wr_en_a    (wr_en_a),
        .wr_en_b    (wr_en_b),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking stream testbench for the 3x3 matrix add / subtract / multiply block.
module testbench
    import mx3_pkg::*;
();

    localparam int N           = DIM_DEFAULT;
    localparam int CELLS       = N * N;
    localparam int S_WIDTH     = ((ELEM_WIDTH_DEFAULT + 7) / 8) * 8;
    localparam int STALL_LIMIT = 2000;
    localparam int RANDOM_ITEMS = 180;

    typedef struct {
        logic signed [OUT_WIDTH-1:0] value;
        logic [IDX_WIDTH-1:0]        row;
        logic [IDX_WIDTH-1:0]        col;
        logic                        last;
    } cell_t;

    logic                     aclk      = 1'b0;
    logic                     aresetn   = 1'b0;
    logic                     s_tvalid  = 1'b0;
    logic                     s_tready;
    logic [S_WIDTH-1:0]       s_tdata   = '0;
    logic                     m_tvalid;
    logic                     m_tready  = 1'b0;
    logic [M_TDATA_WIDTH-1:0] m_tdata;
    logic                     m_tlast;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [OP_WIDTH-1:0]      cfg_data  = OP_ADD;

    // Local copy of the block's state, updated on every accepted item.
    logic signed [ELEM_WIDTH_DEFAULT-1:0] mat_a [CELLS];
    logic signed [ELEM_WIDTH_DEFAULT-1:0] mat_b [CELLS];
    int                  elements_loaded = 0;
    logic [OP_WIDTH-1:0] op_in_force = OP_ADD;
    cell_t               pending_cells [$];

    int   mismatch_count = 0;
    int   items_sent     = 0;
    int   idle_odds      = 3;
    int   ready_hold     = 0;
    int   quiet_cycles   = 0;
    logic quiet_tail     = 1'b0;

    matrix3x3_add_sub_mul i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #10 aclk = ~aclk;

    task automatic report_mismatch(input string field, input longint got, input longint want);
        $display("tb: mismatch on %s at %0t: got %0d, expected %0d",
                 field, $realtime, got, want);
        mismatch_count++;
    endtask

    // Stores one element and, when the second matrix is complete, queues the nine results.
    task automatic load_element(input logic signed [ELEM_WIDTH_DEFAULT-1:0] v);
        longint acc;
        cell_t  res_item;
        if (elements_loaded < CELLS) begin
            mat_a[elements_loaded] = v;
        end else begin
            mat_b[elements_loaded - CELLS] = v;
        end
        elements_loaded++;
        if (elements_loaded == 2 * CELLS) begin
            elements_loaded = 0;
            for (int r = 0; r < N; r++) begin
                for (int c = 0; c < N; c++) begin
                    case (op_in_force)
                        OP_ADD: begin
                            acc = longint'(mat_a[r * N + c]) + longint'(mat_b[r * N + c]);
                        end
                        OP_SUB: begin
                            acc = longint'(mat_a[r * N + c]) - longint'(mat_b[r * N + c]);
                        end
                        default: begin
                            acc = 0;
                            for (int k = 0; k < N; k++) begin
                                acc += longint'(mat_a[r * N + k]) * longint'(mat_b[k * N + c]);
                            end
                        end
                    endcase
                    res_item.value = acc[OUT_WIDTH-1:0];
                    res_item.row   = IDX_WIDTH'(r);
                    res_item.col   = IDX_WIDTH'(c);
                    res_item.last  = (r == N - 1) && (c == N - 1);
                    pending_cells.push_back(res_item);
                end
            end
        end
    endtask

    // Valid is left high after the handshake so that back-to-back items follow without valid dropping between them.
    task automatic send_element(input logic signed [ELEM_WIDTH_DEFAULT-1:0] v);
        if (idle_odds != 0 && !quiet_tail && $urandom_range(0, idle_odds) == 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            s_tdata  <= S_WIDTH'($urandom);
            repeat ($urandom_range(1, 9) - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        do @(posedge aclk); while (!s_tready);
        load_element(v);
        items_sent++;
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_cells.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_operation(input logic [OP_WIDTH-1:0] op);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= op;
        do @(posedge aclk); while (!cfg_ready);
        op_in_force = op;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [ELEM_WIDTH_DEFAULT-1:0] pick_element();
        case ($urandom_range(0, 7))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            2:       return 16'($urandom_range(0, 8)) - 16'sd4;
            default: return 16'($urandom);
        endcase
    endfunction

    // The operation after reset is addition, so this run goes without a register write.
    task automatic test_add_after_reset();
        logic signed [ELEM_WIDTH_DEFAULT-1:0] a_vals [CELLS] =
            '{16'sh7fff, 16'sh8000, 16'sh0000, -16'sd1, 16'sd1,
              16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000};
        logic signed [ELEM_WIDTH_DEFAULT-1:0] b_vals [CELLS] =
            '{16'sh7fff, 16'sh8000, 16'sh8000, -16'sd1, 16'sh7fff,
              16'sh0000, 16'sh7fff, 16'sh8000, 16'sh8000};
        foreach (a_vals[i]) send_element(a_vals[i]);
        foreach (b_vals[i]) send_element(b_vals[i]);
    endtask

    // Both matrices at the most negative value give the largest product sum.
    task automatic test_multiply_extremes();
        wait_drained();
        write_operation(OP_MUL);
        repeat (2 * CELLS) send_element(16'sh8000);
    endtask

    task automatic test_random_runs();
        logic [OP_WIDTH-1:0] op_plan [4] = '{OP_SUB, OP_MUL_ALT, OP_ADD, OP_MUL};
        int phase;
        int start_count;
        phase       = 0;
        start_count = items_sent;
        while (items_sent - start_count < RANDOM_ITEMS) begin
            wait_drained();
            case ($urandom_range(0, 2))
                0:       idle_odds = 0;
                1:       idle_odds = 2;
                default: idle_odds = 6;
            endcase
            write_operation(phase < 4 ? op_plan[phase] : OP_WIDTH'($urandom_range(0, 3)));
            repeat ($urandom_range(1, 3)) begin
                repeat (2 * CELLS) send_element(pick_element());
            end
            phase++;
            if (items_sent - start_count >= RANDOM_ITEMS - 60) quiet_tail = 1'b1;
        end
    endtask

    always @(negedge aclk) begin
        if (quiet_tail || idle_odds == 0) begin
            m_tready <= 1'b1;
        end else if (ready_hold != 0) begin
            ready_hold--;
            m_tready <= 1'b0;
        end else if ($urandom_range(0, idle_odds) == 0) begin
            ready_hold = $urandom_range(0, 8);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        cell_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_cells.size() == 0) begin
                report_mismatch("unexpected result_value",
                                longint'($signed(m_tdata[OUT_WIDTH-1:0])), 0);
            end else begin
                want = pending_cells.pop_front();
                if (m_tdata[OUT_WIDTH-1:0] !== want.value) begin
                    report_mismatch("result_value", longint'($signed(m_tdata[OUT_WIDTH-1:0])),
                                    longint'(want.value));
                end
                if (m_tdata[OUT_WIDTH+IDX_WIDTH-1:OUT_WIDTH] !== want.row) begin
                    report_mismatch("result_row",
                                    longint'(m_tdata[OUT_WIDTH+IDX_WIDTH-1:OUT_WIDTH]),
                                    longint'(want.row));
                end
                if (m_tdata[OUT_WIDTH+2*IDX_WIDTH-1:OUT_WIDTH+IDX_WIDTH] !== want.col) begin
                    report_mismatch("result_col",
                                    longint'(m_tdata[OUT_WIDTH+2*IDX_WIDTH-1:OUT_WIDTH+IDX_WIDTH]),
                                    longint'(want.col));
                end
                if (m_tlast !== want.last) begin
                    report_mismatch("last_of_run", longint'(m_tlast), longint'(want.last));
                end
            end
        end
    end

    // The run is abandoned when no item moves on any channel for too long.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                (cfg_valid && cfg_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial begin
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_add_after_reset();
        test_multiply_extremes();
        test_random_runs();
        wait_drained();
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
